[rtl/gphr_pkg.sv]
`default_nettype none

package gphr_pkg;

  // Default sizes
  localparam int unsigned ChannelsDef  = 24;
  localparam int unsigned CountBitsDef = 16;

  // Channels with a real source; the rest read as released
  localparam int unsigned KeyChannels = 24;
  localparam int unsigned MaskBits    = 24;

  // Channel map landmarks
  localparam logic [4:0] ChanLt     = 5'd6;
  localparam logic [4:0] ChanRt     = 5'd7;
  localparam logic [4:0] ChanStick0 = 5'd16;
  localparam logic [4:0] ChanEnd    = 5'd24;

  // Repeat number saturation
  localparam logic [13:0] RepeatMax = 14'd16383;

  // Divider quotient bits per cycle
  localparam int unsigned DivStep = 4;

  // Configuration register indexes
  localparam logic [2:0] CfgDelay    = 3'd0;
  localparam logic [2:0] CfgInterval = 3'd1;
  localparam logic [2:0] CfgSPress   = 3'd2;
  localparam logic [2:0] CfgSRelease = 3'd3;
  localparam logic [2:0] CfgTPress   = 3'd4;
  localparam logic [2:0] CfgTRelease = 3'd5;

  // Configuration reset values
  localparam logic [15:0] DelayRst    = 16'd30;
  localparam logic [7:0]  IntervalRst = 8'd6;
  localparam logic [15:0] SPressRst   = 16'd18432;
  localparam logic [15:0] SReleaseRst = 16'd16384;
  localparam logic [7:0]  TPressRst   = 8'd144;
  localparam logic [8:0]  TReleaseRst = 9'd128;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;
  typedef logic [4:0]  chan_t;

  // Per-channel decision of one poll
  typedef enum logic [1:0] {
    DEC_RELEASE = 2'd0,
    DEC_PRESS   = 2'd1,
    DEC_HOLD    = 2'd2
  } dec_e;

  typedef struct packed {
    logic [15:0] delay;
    logic [7:0]  interval;
    logic [15:0] s_press;
    logic [15:0] s_release;
    logic [7:0]  t_press;
    logic [8:0]  t_release;
  } cfg_t;

  typedef struct packed {
    logic               reading_valid;
    logic [15:0]        button_bits;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic               window_focused;
  } in_t;

  typedef struct packed {
    logic [4:0]  channel;
    logic [13:0] repeat_number;
    logic [23:0] pressed_mask;
    logic        last_event;
  } out_t;

  // One logged event of a tick
  typedef struct packed {
    chan_t       channel;
    logic [13:0] repeat_number;
  } evt_t;

  // Index width for a store of n entries
  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Button mask bit feeding each button channel
  function automatic logic [3:0] button_bit(chan_t ch);
    logic [3:0] b;
    case (ch)
      5'd0:    b = 4'd12;
      5'd1:    b = 4'd13;
      5'd2:    b = 4'd14;
      5'd3:    b = 4'd15;
      5'd4:    b = 4'd9;
      5'd5:    b = 4'd8;
      5'd8:    b = 4'd0;
      5'd9:    b = 4'd1;
      5'd10:   b = 4'd2;
      5'd11:   b = 4'd3;
      5'd12:   b = 4'd4;
      5'd13:   b = 4'd5;
      5'd14:   b = 4'd6;
      5'd15:   b = 4'd7;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/gphr_ram.sv]
`default_nettype none

module gphr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 24
) (
  input  wire                                    clk_i,
  input  wire                                    we_i,
  input  wire  [gphr_pkg::idx_w(Depth)-1:0]      waddr_i,
  input  wire  [Width-1:0]                       wdata_i,
  input  wire  [gphr_pkg::idx_w(Depth)-1:0]      raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/gphr_decode.sv]
`default_nettype none

module gphr_decode (
  input  wire  gphr_pkg::chan_t ch_i,
  input  wire  gphr_pkg::in_t   poll_i,
  input  wire  gphr_pkg::cfg_t  cfg_i,
  output gphr_pkg::dec_e        dec_o
);

  import gphr_pkg::*;

  // Hysteresis compare of one analog magnitude
  function automatic dec_e analog_dec(logic [16:0] mag, logic [16:0] press,
                                      logic [16:0] release_lvl);
    dec_e d;
    if (mag >= press) begin
      d = DEC_PRESS;
    end else if (mag < release_lvl) begin
      d = DEC_RELEASE;
    end else begin
      d = DEC_HOLD;
    end
    return d;
  endfunction

  chan_t       k;
  logic [15:0] axis;
  logic [15:0] mag;
  logic [7:0]  trig;

  always_comb begin
    k    = ch_i - ChanStick0;
    trig = (ch_i == ChanLt) ? poll_i.left_trigger : poll_i.right_trigger;

    // Half-axis source: up/down use y, right/left use x
    if (!k[1]) begin
      axis = k[2] ? poll_i.right_y : poll_i.left_y;
    end else begin
      axis = k[2] ? poll_i.right_x : poll_i.left_x;
    end

    // Magnitude on this side, zero on the other
    mag = '0;
    if (!k[0]) begin
      if (!axis[15] && (axis != 16'd0)) begin
        mag = axis;
      end
    end else if (axis[15]) begin
      mag = ~axis + 16'd1;
    end

    if (ch_i >= ChanEnd) begin
      dec_o = DEC_RELEASE;
    end else if ((ch_i == ChanLt) || (ch_i == ChanRt)) begin
      dec_o = analog_dec({9'd0, trig}, {9'd0, cfg_i.t_press}, {8'd0, cfg_i.t_release});
    end else if (ch_i < ChanStick0) begin
      dec_o = poll_i.button_bits[button_bit(ch_i)] ? DEC_PRESS : DEC_RELEASE;
    end else begin
      dec_o = analog_dec({1'b0, mag}, {1'b0, cfg_i.s_press}, {1'b0, cfg_i.s_release});
    end
  end

endmodule

`default_nettype wire

[rtl/gphr_div.sv]
`default_nettype none

module gphr_div #(
  parameter int unsigned NumBits = gphr_pkg::CountBitsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire  [NumBits-1:0] dividend_i,
  input  wire  [7:0]         divisor_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o,
  output logic [7:0]         rem_o
);

  import gphr_pkg::*;

  localparam int unsigned Iters = (NumBits + DivStep - 1) / DivStep;
  localparam int unsigned PadW  = Iters * DivStep;
  localparam int unsigned IterW = idx_w(Iters);

  logic [PadW-1:0]  dvd_q;
  logic [7:0]       rem_q;
  logic [7:0]       dvs_q;
  logic [IterW-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [PadW-1:0]  dvd_d;
  logic [7:0]       rem_d;
  logic [8:0]       trial;

  // Restoring division, DivStep quotient bits per cycle
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    trial = '0;
    for (int k = 0; k < DivStep; k++) begin
      trial = {rem_d, dvd_d[PadW-1]};
      dvd_d = {dvd_d[PadW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        dvd_d[0] = 1'b1;
      end
      rem_d = trial[7:0];
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + IterW'(1);
        if (cnt_q == IterW'(Iters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath; the quotient shifts in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= PadW'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[NumBits-1:0];
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[rtl/gamepad_press_hysteresis_repeat_core.sv]
// Flow: per channel, the hold count is read (ST_READ) and then evaluated (ST_EVAL); a held
// channel past the repeat delay also waits on the shared repeat divider (ST_DIV), and the
// tick's events then leave the event buffer one by one (ST_EMIT_RD, ST_EMIT_LD).
// A new poll is taken only in ST_IDLE, once the previous channel walk and drain are done.
// Reset: asynchronous, active low; press flags and hold counts clear (count valid
// bits), configuration returns to its defaults, no pending transactions remain.
`default_nettype none

module gamepad_press_hysteresis_repeat_core #(
  parameter int unsigned CHANNELS   = gphr_pkg::ChannelsDef,
  parameter int unsigned COUNT_BITS = gphr_pkg::CountBitsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  gphr_pkg::cfg_idx_t  cfg_index_i,
  input  wire  gphr_pkg::cfg_data_t cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  gphr_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output gphr_pkg::out_t       out_data_o
);

  import gphr_pkg::*;

  localparam int unsigned ChW = idx_w(CHANNELS);
  localparam int unsigned NW  = $clog2(CHANNELS + 1);
  localparam logic [ChW-1:0]        ChLast = ChW'(CHANNELS - 1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_READ    = 6'b000010,
    ST_EVAL    = 6'b000100,
    ST_DIV     = 6'b001000,
    ST_EMIT_RD = 6'b010000,
    ST_EMIT_LD = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [ChW-1:0]       ch_q, ch_d;
  logic [NW-1:0]        evn_q, evn_d;
  logic [ChW-1:0]       rd_q, rd_d;
  logic [CHANNELS-1:0]  flags_q, flags_d;
  logic [CHANNELS-1:0]  cvld_q;
  cfg_t                 cfg_q;
  in_t                  poll_q;
  logic                 focus_q;
  out_t                 out_q;
  logic                 out_vld_q;

  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  ev_we;
  evt_t                  ev_wdata;
  evt_t                  ev_rdata;
  dec_e                  dec;
  logic                  flag_new;
  logic                  has_ev;
  logic [13:0]           ev_num;
  logic                  advance;
  logic                  out_load;
  logic                  out_last;
  logic                  div_start;
  logic                  div_done;
  logic [COUNT_BITS-1:0] div_dividend;
  logic [COUNT_BITS-1:0] div_quot;
  logic [7:0]            div_rem;
  logic [7:0]            interval;
  logic [32:0]           quot_x;
  logic [13:0]           rep_num;
  logic [MaskBits-1:0]   pmask;

  // Hold count store, one entry per channel
  gphr_ram #(
    .Width (COUNT_BITS),
    .Depth (CHANNELS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (ch_q),
    .wdata_i (cnt_wdata),
    .raddr_i (ch_q),
    .rdata_o (cnt_rdata)
  );

  // Events of the current tick, emitted once the mask is final
  gphr_ram #(
    .Width ($bits(evt_t)),
    .Depth (CHANNELS)
  ) u_evt_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (evn_q[ChW-1:0]),
    .wdata_i (ev_wdata),
    .raddr_i (rd_q),
    .rdata_o (ev_rdata)
  );

  gphr_decode u_decode (
    .ch_i   (5'(ch_q)),
    .poll_i (poll_q),
    .cfg_i  (cfg_q),
    .dec_o  (dec)
  );

  gphr_div #(
    .NumBits (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (interval),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Channel datapath
  assign cnt_cur      = cvld_q[ch_q] ? cnt_rdata : '0;
  assign cnt_inc      = cnt_cur + CntOne;
  assign div_dividend = COUNT_BITS'(33'(cnt_inc) - 33'(cfg_q.delay));
  assign interval     = (cfg_q.interval == 8'd0) ? 8'd1 : cfg_q.interval;
  assign quot_x       = 33'(div_quot);
  assign rep_num      = (quot_x >= 33'(RepeatMax)) ? RepeatMax : 14'(quot_x + 33'd1);
  assign out_last     = (NW'(rd_q) + NW'(1)) == evn_q;

  always_comb begin
    unique case (dec)
      DEC_PRESS:   flag_new = 1'b1;
      DEC_RELEASE: flag_new = 1'b0;
      default:     flag_new = flags_q[ch_q];
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    evn_d     = evn_q;
    rd_d      = rd_q;
    flags_d   = flags_q;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_inc;
    has_ev    = 1'b0;
    ev_num    = '0;
    div_start = 1'b0;
    advance   = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d    = '0;
          evn_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        flags_d[ch_q] = flag_new;
        advance       = 1'b1;
        if (flag_new) begin
          if (cnt_cur != CntMax) begin
            cnt_we = 1'b1;
            if (cnt_inc == CntOne) begin
              has_ev = 1'b1;
              ev_num = 14'd1;
            end else if (33'(cnt_inc) > 33'(cfg_q.delay)) begin
              div_start = 1'b1;
              advance   = 1'b0;
              state_d   = ST_DIV;
            end
          end
        end else if (cnt_cur != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = '0;
          has_ev    = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          advance = 1'b1;
          if (div_rem == 8'd0) begin
            has_ev = 1'b1;
            ev_num = rep_num;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          if (out_last) begin
            state_d = ST_IDLE;
          end else begin
            rd_d    = rd_q + ChW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Log events only for a focused tick
    ev_we = has_ev && focus_q;
    if (ev_we) begin
      evn_d = evn_q + NW'(1);
    end

    // Next channel, or drain the tick's events
    if (advance) begin
      if (ch_q == ChLast) begin
        ch_d    = '0;
        rd_d    = '0;
        state_d = (evn_d == '0) ? ST_IDLE : ST_EMIT_RD;
      end else begin
        ch_d    = ch_q + ChW'(1);
        state_d = ST_READ;
      end
    end
  end

  assign ev_wdata.channel       = 5'(ch_q);
  assign ev_wdata.repeat_number = ev_num;

  // Press mask over the mapped channels
  for (genvar i = 0; i < MaskBits; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign pmask[i] = flags_q[i];
    end else begin : g_off
      assign pmask[i] = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= '0;
      evn_q     <= '0;
      rd_q      <= '0;
      flags_q   <= '0;
      cvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      evn_q   <= evn_d;
      rd_q    <= rd_d;
      flags_q <= flags_d;
      if (cnt_we) begin
        cvld_q[ch_q] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay     <= DelayRst;
      cfg_q.interval  <= IntervalRst;
      cfg_q.s_press   <= SPressRst;
      cfg_q.s_release <= SReleaseRst;
      cfg_q.t_press   <= TPressRst;
      cfg_q.t_release <= TReleaseRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDelay:    cfg_q.delay     <= cfg_data_i;
        CfgInterval: cfg_q.interval  <= cfg_data_i[7:0];
        CfgSPress:   cfg_q.s_press   <= cfg_data_i;
        CfgSRelease: cfg_q.s_release <= cfg_data_i;
        CfgTPress:   cfg_q.t_press   <= cfg_data_i[7:0];
        CfgTRelease: cfg_q.t_release <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Poll capture; an invalid poll reads as all zeros
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      poll_q  <= in_data_i.reading_valid ? in_data_i : '0;
      focus_q <= in_data_i.window_focused;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.channel       <= ev_rdata.channel;
      out_q.repeat_number <= ev_rdata.repeat_number;
      out_q.pressed_mask  <= pmask;
      out_q.last_event    <= out_last;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/gphr_checker.sv]
`default_nettype none

module gphr_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input wire gphr_pkg::out_t out_data_o
);

  // A stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Press events carry their own bit set, release events carry it clear
  a_mask_matches_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.pressed_mask[out_data_o.channel] == (out_data_o.repeat_number != 14'd0)))
    else $error("pressed mask disagrees with event kind");

  // A poll transaction starts a channel walk; no second poll right behind it
  a_busy_after_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("poll taken while the previous one is in work");

endmodule

bind gamepad_press_hysteresis_repeat_core gphr_checker u_gphr_checker (.*);

`default_nettype wire
